// ----- sv/gbc_pkg.sv -----
// Shared constants for the clamped 3x3 blur block.
// No dependencies; imported by gbc_div and gaussian_blur_3x3_clamped.
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int WID_W     = 11;
  localparam int WT_W      = 24;
  localparam int DIV_W     = 12;
  // 9 taps of 8x8 products: 9 * 255 * 255 < 2**20
  localparam int SUM_W     = 20;
  localparam int QUO_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WT_TOP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WT_MID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WT_BOT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd5;

endpackage

`default_nettype wire

// ----- sv/gbc_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating at 255.
// Depends on gbc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module gbc_div
  import gbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [QUO_W-1:0]      quot
);

  localparam int DSH_W = DIV_W + QUO_W - 1;

  logic [SUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [2:0]       cnt;
  logic             ge;

  assign ge = rem >= SUM_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // zero divisor or quotient beyond 8 bits: saturate right away
        if (divisor == '0 || dividend >= {divisor, {QUO_W{1'b0}}}) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= {divisor, {(QUO_W-1){1'b0}}};
      cnt  <= 3'(QUO_W - 1);
      quot <= (divisor == '0 || dividend >= {divisor, {QUO_W{1'b0}}}) ? '1 : '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - SUM_W'(dsh);
      end
      quot <= {quot[QUO_W-2:0], ge};
      dsh  <= dsh >> 1;
      cnt  <= cnt - 3'd1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gaussian_blur_3x3_clamped.sv -----
// 3x3 blur with clamp-to-edge borders: line store memory, window, MAC and divider.
// Depends on gbc_pkg and gbc_div.
// One pixel word at a time: each pixel is read, then each result it completes goes through
// the row MAC and the bit-serial divider and is sent before the next pixel is taken.
// The line stores share one 1024 x 16 memory, read once and written once per pixel.
// Synchronous reset clears position, window, sequencer and registers to defaults;
// line store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_3x3_clamped
  import gbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave stream: [7:0] pixel
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,
  // master stream: [7:0] filtered, [19:8] out_row, [29:20] out_col, [31:30] zero
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,
  output logic                      m_tlast,  // frame_last
  // configuration write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WT_W-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_DIVGO = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state;

  // configuration registers
  logic [WID_W-1:0] reg_width;
  logic [ROW_W-1:0] reg_height;
  logic [WT_W-1:0]  wt_top, wt_mid, wt_bot;
  logic [DIV_W-1:0] reg_div;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= WID_W'(1024);
      reg_height <= ROW_W'(1024);
      wt_top     <= WT_W'(66049);
      wt_mid     <= WT_W'(132098);
      wt_bot     <= WT_W'(66049);
      reg_div    <= DIV_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:   reg_width  <= cfg_data[WID_W-1:0];
        REG_HEIGHT:  reg_height <= cfg_data[ROW_W-1:0];
        REG_WT_TOP:  wt_top     <= cfg_data;
        REG_WT_MID:  wt_mid     <= cfg_data;
        REG_WT_BOT:  wt_bot     <= cfg_data;
        REG_DIVISOR: reg_div    <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped position of the incoming pixel
  logic [WID_W-1:0] w_eff, w_m1;
  logic [ROW_W-1:0] h_eff, h_m1;
  logic [ROW_W-1:0] in_row, i_c;
  logic [COL_W-1:0] in_col, j_c;

  always_comb begin
    if (reg_width == '0) begin
      w_eff = WID_W'(1);
    end else if (reg_width > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = reg_width;
    end
    h_eff = (reg_height == '0) ? ROW_W'(1) : reg_height;
    w_m1  = w_eff - WID_W'(1);
    h_m1  = h_eff - ROW_W'(1);
    i_c   = (in_row < h_m1) ? in_row : h_m1;
    j_c   = (WID_W'(in_col) < w_m1) ? in_col : w_m1[COL_W-1:0];
  end

  logic             in_acc;
  logic [ROW_W-1:0] cur_i;
  logic [COL_W-1:0] cur_j;
  logic             last_col, last_row;
  logic [PIX_W-1:0] pix;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // line stores: [15:8] two rows up, [7:0] one row up
  logic [2*PIX_W-1:0] lmem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]   above2, above1, keep_a;
  logic               mem_we;

  assign above2 = (cur_i >= ROW_W'(2)) ? rd_data[15:8] : '0;
  assign above1 = (cur_i >= ROW_W'(1)) ? rd_data[7:0] : '0;
  assign keep_a = (cur_i >= ROW_W'(1)) ? above1 : rd_data[15:8];
  assign mem_we = (state == ST_READ);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= lmem[j_c[ADDR_W-1:0]];
    end
    if (mem_we) begin
      lmem[cur_j[ADDR_W-1:0]] <= {keep_a, pix};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_i    <= i_c;
      cur_j    <= j_c;
      last_col <= (WID_W'(j_c) == w_m1);
      last_row <= (i_c == h_m1);
      pix      <= s_tdata;
    end
  end

  // window rows, column 2 (newest) in the high byte
  logic [3*PIX_W-1:0] win0, win1, win2;
  logic [3:0]         pend;
  logic [1:0]         res_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      win0   <= '0;
      win1   <= '0;
      win2   <= '0;
      in_row <= '0;
      in_col <= '0;
    end else if (state == ST_READ) begin
      win0 <= {above2, win0[23:8]};
      win1 <= {above1, win1[23:8]};
      win2 <= {pix, win2[23:8]};
      if (last_col) begin
        in_col <= '0;
        in_row <= last_row ? '0 : cur_i + ROW_W'(1);
      end else begin
        in_col <= cur_j + COL_W'(1);
        in_row <= cur_i;
      end
    end
  end

  // row and column selection of the result being worked on
  logic [1:0] rt0, rt1, cl0, cl1;
  logic [1:0] rs0, rs1, rs2, cs0, cs1, cs2;

  always_comb begin
    rt0 = (cur_i >= ROW_W'(2)) ? 2'd0 : 2'd1;
    rt1 = (cur_i >= ROW_W'(1)) ? 2'd1 : 2'd2;
    cl0 = (cur_j >= COL_W'(2)) ? 2'd0 : 2'd1;
    cl1 = (cur_j >= COL_W'(1)) ? 2'd1 : 2'd2;
    if (res_k[1]) begin
      rs0 = rt1; rs1 = 2'd2; rs2 = 2'd2;
    end else begin
      rs0 = rt0; rs1 = 2'd1; rs2 = 2'd2;
    end
    if (res_k[0]) begin
      cs0 = cl1; cs1 = 2'd2; cs2 = 2'd2;
    end else begin
      cs0 = cl0; cs1 = 2'd1; cs2 = 2'd2;
    end
  end

  function automatic logic [7:0] byte3(input logic [23:0] v, input logic [1:0] s);
    case (s)
      2'd0:    byte3 = v[7:0];
      2'd1:    byte3 = v[15:8];
      default: byte3 = v[23:16];
    endcase
  endfunction

  function automatic logic [23:0] row3(input logic [23:0] a, input logic [23:0] b,
                                       input logic [23:0] c, input logic [1:0] s);
    case (s)
      2'd0:    row3 = a;
      2'd1:    row3 = b;
      default: row3 = c;
    endcase
  endfunction

  // MAC: one kernel row per cycle
  logic [1:0]       mac_cnt;
  logic [1:0]       rsel;
  logic [23:0]      wrow, prow;
  logic [15:0]      p0, p1, p2;
  logic [17:0]      row_sum;
  logic [SUM_W-1:0] acc;

  always_comb begin
    rsel    = (mac_cnt == 2'd0) ? rs0 : ((mac_cnt == 2'd1) ? rs1 : rs2);
    wrow    = row3(wt_top, wt_mid, wt_bot, mac_cnt);
    prow    = row3(win0, win1, win2, rsel);
    p0      = wrow[7:0]   * byte3(prow, cs0);
    p1      = wrow[15:8]  * byte3(prow, cs1);
    p2      = wrow[23:16] * byte3(prow, cs2);
    row_sum = 18'(p0) + 18'(p1) + 18'(p2);
  end

  logic             div_start, div_busy, div_done;
  logic [QUO_W-1:0] div_q;

  assign div_start = (state == ST_DIVGO);

  gbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (reg_div),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  logic out_free, out_load;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_OUT) && out_free;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pend    <= '0;
      mac_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          pend[0] <= (cur_i >= ROW_W'(1)) && (cur_j >= COL_W'(1));
          pend[1] <= (cur_i >= ROW_W'(1)) && last_col;
          pend[2] <= last_row && (cur_j >= COL_W'(1));
          pend[3] <= last_row && last_col;
          state   <= ST_PICK;
        end
        ST_PICK: begin
          mac_cnt <= '0;
          state   <= (pend == '0) ? ST_IDLE : ST_MAC;
        end
        ST_MAC: begin
          mac_cnt <= mac_cnt + 2'd1;
          if (mac_cnt == 2'd2) begin
            state <= ST_DIVGO;
          end
        end
        ST_DIVGO: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            pend[res_k] <= 1'b0;
            state       <= ST_PICK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PICK) begin
      acc <= '0;
      if (pend[0]) begin
        res_k <= 2'd0;
      end else if (pend[1]) begin
        res_k <= 2'd1;
      end else if (pend[2]) begin
        res_k <= 2'd2;
      end else begin
        res_k <= 2'd3;
      end
    end else if (state == ST_MAC) begin
      acc <= acc + SUM_W'(row_sum);
    end
  end

  // output register
  logic [ROW_W-1:0] o_row;
  logic [COL_W-1:0] o_col;

  assign o_row = res_k[1] ? cur_i : cur_i - ROW_W'(1);
  assign o_col = res_k[0] ? cur_j : cur_j - COL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, o_col, o_row, div_q};
      m_tlast <= (res_k == 2'd3);
    end
  end

  // no pixel is taken while the memory write of the previous one is pending
  a_no_acc_on_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !in_acc)
    else $error("pixel accepted during line store write");

  // results on the row above need a row above
  a_pend_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) && (pend[0] || pend[1]) |-> cur_i != '0)
    else $error("result pending above row 0");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && (m_tlast == $past(res_k == 2'd3)))
    else $error("output register not loaded");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside wait state");

endmodule

`default_nettype wire
